// ----- rtl/min_heap_priority_queue_unit_macros.svh -----
// ---------------------------------------------------------------------------
// min heap priority queue macros
// assertion helpers for the queue unit, empty for synthesis
// ---------------------------------------------------------------------------
`ifndef MIN_HEAP_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define MIN_HEAP_PRIORITY_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// property checked at every edge outside reset
`define MHPQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication checked in the cycle after its antecedent, outside reset
`define MHPQ_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define MHPQ_ASSERT(lbl, clk, rst, prop, msg)
`define MHPQ_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif

`endif

// ----- rtl/mhpq_pkg.sv -----
// ---------------------------------------------------------------------------
// mhpq_pkg
// widths, codes and the store request type of the min heap priority queue
// ---------------------------------------------------------------------------
package mhpq_pkg;

  localparam int KEY_W    = 32;
  localparam int ADDR_W   = 7;
  localparam int DEPTH    = 2 ** ADDR_W;
  localparam int CAPACITY = DEPTH - 1;
  localparam int STAT_W   = 3;
  localparam int ACT_W    = 2;

  localparam logic [ACT_W-1:0] ACT_INSERT   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_EXTRACT  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DECREASE = 2'd2;
  localparam logic [ACT_W-1:0] ACT_DELETE   = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 3'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTDEC = 3'd4;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [KEY_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// ----- rtl/mhpq_store.sv -----
// ---------------------------------------------------------------------------
// mhpq_store
// key store of the heap: one write port, one read port, registered read data
// ---------------------------------------------------------------------------
module mhpq_store (
  input  logic                            clk,
  input  mhpq_pkg::mem_req_t              req,
  output logic [mhpq_pkg::KEY_W-1:0]      rdata
);

  logic [mhpq_pkg::KEY_W-1:0] mem [mhpq_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ----- rtl/min_heap_priority_queue_unit.sv -----
// ---------------------------------------------------------------------------
// min_heap_priority_queue_unit
// binary min heap of signed keys with insert, extract, decrease and delete
// ---------------------------------------------------------------------------
// One request is worked on at a time; a finished result sits in the output
// register while the next request is taken. All keys live in a single store
// with one read and one write port and registered read data, so the
// time per request follows the heap depth: each level of sift-up passes
// SU_CHK and SU_CMP, each level of the raise of a deleted entry RAISE_CHK
// and RAISE_WR, each level of sift-down SD_CHK, SD_RDR and SD_CMP. A
// rejected request goes from IDLE through ROOT_RD to DONE, a decrease
// with a larger key by way of DEC_CMP. There is no clearing pass after
// reset; entries are only used once written.
module min_heap_priority_queue_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // action[1:0], key_value[33:2], position[40:34], zero fill
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // removed_value[31:0], min_after[63:32], count_after[70:64], status[73:71], zero fill
  output logic [79:0] m_axis_tdata
);

  `include "min_heap_priority_queue_unit_macros.svh"

  localparam int KW = mhpq_pkg::KEY_W;
  localparam int AW = mhpq_pkg::ADDR_W;

  typedef enum logic [3:0] {
    IDLE, DEC_CMP, DEL_GET, EX_GET, RAISE_CHK, RAISE_WR, TAKE, TAKE_GET,
    SU_CHK, SU_CMP, SD_CHK, SD_RDR, SD_CMP, ROOT_RD, DONE
  } state_t;

  state_t                          state;
  logic [AW-1:0]                   cnt;
  logic [AW-1:0]                   p;
  logic signed [KW-1:0]            v;
  logic signed [KW-1:0]            lval;
  logic                            has_r;
  logic signed [KW-1:0]            removed;
  logic [mhpq_pkg::STAT_W-1:0]     status;

  logic                            m_valid;
  logic [KW-1:0]                   o_removed;
  logic [KW-1:0]                   o_min;
  logic [AW-1:0]                   o_count;
  logic [mhpq_pkg::STAT_W-1:0]     o_status;

  mhpq_pkg::mem_req_t              mem_req;
  logic [KW-1:0]                   rdata;
  logic signed [KW-1:0]            rkey;

  logic [mhpq_pkg::ACT_W-1:0]      in_action;
  logic signed [KW-1:0]            in_key;
  logic [AW-1:0]                   in_pos;
  logic                            pos_ok;

  logic [AW:0]                     l8;
  logic [AW:0]                     r8;
  logic                            has_l;
  logic                            r_ok;
  logic                            parent_gt;
  logic                            l_lt;
  logic                            r_lt;
  logic signed [KW-1:0]            best;
  logic                            go_down;
  logic signed [KW-1:0]            child_val;
  logic [AW-1:0]                   child_pos;

  mhpq_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  assign in_action = s_axis_tdata[1:0];
  assign in_key    = s_axis_tdata[33:2];
  assign in_pos    = s_axis_tdata[40:34];
  assign pos_ok    = (in_pos != '0) && (in_pos <= cnt);

  assign rkey      = rdata;
  assign l8        = {p, 1'b0};
  assign r8        = {p, 1'b1};
  // p <= cnt/2 is the same as 2p <= cnt
  assign has_l     = l8 <= {1'b0, cnt};
  assign r_ok      = r8 <= {1'b0, cnt};
  assign parent_gt = rkey > v;

  // smaller child, left wins a tie, only if strictly below the moving key
  assign l_lt      = lval < v;
  assign best      = l_lt ? lval : v;
  assign r_lt      = has_r && (rkey < best);
  assign go_down   = l_lt || r_lt;
  assign child_val = r_lt ? rkey : lval;
  assign child_pos = r_lt ? r8[AW-1:0] : l8[AW-1:0];

  always_comb begin
    mem_req       = '0;
    mem_req.wdata = v;
    case (state)
      IDLE: begin
        mem_req.re    = s_axis_tvalid;
        mem_req.raddr = (in_action == mhpq_pkg::ACT_EXTRACT) ? AW'(1) : in_pos;
      end
      RAISE_CHK: begin
        mem_req.re    = (p != AW'(1));
        mem_req.raddr = p >> 1;
      end
      RAISE_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = p;
        mem_req.wdata = rkey;
      end
      TAKE: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = cnt;
      end
      SU_CHK: begin
        mem_req.we    = (p == AW'(1));
        mem_req.waddr = p;
        mem_req.re    = (p != AW'(1));
        mem_req.raddr = p >> 1;
      end
      SU_CMP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = p;
        mem_req.wdata = parent_gt ? rkey : v;
      end
      SD_CHK: begin
        mem_req.re    = has_l;
        mem_req.raddr = l8[AW-1:0];
        mem_req.we    = !has_l;
        mem_req.waddr = p;
      end
      SD_RDR: begin
        mem_req.re    = r_ok;
        mem_req.raddr = r8[AW-1:0];
      end
      SD_CMP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = p;
        mem_req.wdata = go_down ? child_val : v;
      end
      ROOT_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = AW'(1);
      end
      default: begin
        mem_req.re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      cnt     <= '0;
      m_valid <= 1'b0;
    end else begin
      if (m_valid && m_axis_tready && (state != DONE)) begin
        m_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_axis_tvalid) begin
            removed <= '0;
            status  <= mhpq_pkg::ST_OK;
            v       <= in_key;
            p       <= in_pos;
            case (in_action)
              mhpq_pkg::ACT_INSERT: begin
                if (cnt >= AW'(mhpq_pkg::CAPACITY)) begin
                  status <= mhpq_pkg::ST_FULL;
                  state  <= ROOT_RD;
                end else begin
                  cnt   <= cnt + AW'(1);
                  p     <= cnt + AW'(1);
                  state <= SU_CHK;
                end
              end
              mhpq_pkg::ACT_EXTRACT: begin
                if (cnt == '0) begin
                  status <= mhpq_pkg::ST_EMPTY;
                  state  <= ROOT_RD;
                end else begin
                  state <= EX_GET;
                end
              end
              mhpq_pkg::ACT_DECREASE: begin
                if (!pos_ok) begin
                  status <= mhpq_pkg::ST_BADPOS;
                  state  <= ROOT_RD;
                end else begin
                  state <= DEC_CMP;
                end
              end
              default: begin
                if (!pos_ok) begin
                  status <= mhpq_pkg::ST_BADPOS;
                  state  <= ROOT_RD;
                end else begin
                  state <= DEL_GET;
                end
              end
            endcase
          end
        end
        DEC_CMP: begin
          if (v > rkey) begin
            status <= mhpq_pkg::ST_NOTDEC;
            state  <= ROOT_RD;
          end else begin
            state <= SU_CHK;
          end
        end
        DEL_GET: begin
          removed <= rkey;
          state   <= RAISE_CHK;
        end
        EX_GET: begin
          removed <= rkey;
          state   <= TAKE;
        end
        RAISE_CHK: begin
          state <= (p == AW'(1)) ? TAKE : RAISE_WR;
        end
        RAISE_WR: begin
          p     <= p >> 1;
          state <= RAISE_CHK;
        end
        TAKE: begin
          state <= TAKE_GET;
        end
        TAKE_GET: begin
          v     <= rkey;
          cnt   <= cnt - AW'(1);
          p     <= AW'(1);
          state <= SD_CHK;
        end
        SU_CHK: begin
          state <= (p == AW'(1)) ? ROOT_RD : SU_CMP;
        end
        SU_CMP: begin
          if (parent_gt) begin
            p     <= p >> 1;
            state <= SU_CHK;
          end else begin
            state <= ROOT_RD;
          end
        end
        SD_CHK: begin
          state <= has_l ? SD_RDR : ROOT_RD;
        end
        SD_RDR: begin
          lval  <= rkey;
          has_r <= r_ok;
          state <= SD_CMP;
        end
        SD_CMP: begin
          if (go_down) begin
            p     <= child_pos;
            state <= SD_CHK;
          end else begin
            state <= ROOT_RD;
          end
        end
        ROOT_RD: begin
          state <= DONE;
        end
        DONE: begin
          // root read data holds here until the output slot frees up
          if (!m_valid || m_axis_tready) begin
            m_valid   <= 1'b1;
            o_removed <= removed;
            o_min     <= (cnt != '0) ? rdata : '0;
            o_count   <= cnt;
            o_status  <= status;
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state == IDLE);
  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {6'b0, o_status, o_count, o_min, o_removed};

  `MHPQ_ASSERT_NEXT(a_cnt_step, clk, rst, 1'b1, (cnt == $past(cnt)) || (cnt == $past(cnt) + AW'(1)) || (cnt == $past(cnt) - AW'(1)), "count moved by more than one")
  `MHPQ_ASSERT(a_cnt_cap, clk, rst, cnt <= AW'(mhpq_pkg::CAPACITY), "count above capacity")
  `MHPQ_ASSERT(a_wr_busy, clk, rst, !mem_req.we || ((state != IDLE) && (mem_req.waddr != '0)), "store write while idle or to slot zero")
  `MHPQ_ASSERT(a_out_rise, clk, rst, !$rose(m_axis_tvalid) || $past(state == DONE), "result shown without a finished request")

endmodule
